/* rtl/stdq_pkg.sv */
// Shared types and codes for the sorted timer deadline queue.
// Used by stdq_cell and sorted_timer_deadline_queue_core; no dependencies.
package stdq_pkg;

    localparam int ID_W       = 4;
    localparam int SEC_W      = 32;
    localparam int USEC_W     = 20;
    localparam int NUM_TIMERS = 16;

    // one second in microseconds, one bit wider than the field for the borrow sum
    localparam logic [USEC_W:0] USEC_PER_SEC = 21'd1000000;

    // register index taken from paddr[2]
    localparam logic REG_IDLE_SEC  = 1'b0;
    localparam logic REG_IDLE_USEC = 1'b1;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_TICK   = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_EXPIRED = 2'd0,
        KIND_SLEEP   = 2'd1,
        KIND_INS     = 2'd2,
        KIND_DEL     = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_IGNORED = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INS,
        S_DEL,
        S_TICK
    } t_state;

    typedef struct packed {
        logic [SEC_W-1:0]  sec;
        logic [USEC_W-1:0] usec;
        logic [ID_W-1:0]   owner;
    } t_slot;

    // per-cell update controls
    typedef struct packed {
        logic ins;   // insert broadcast: cells at or past the slot position load
        logic shl;   // take the right neighbor's entry
    } t_cell_ctl;

    // per-cell compare results against the broadcast entry
    typedef struct packed {
        logic take;  // this cell is at or past the insert position
        logic ge;    // stored deadline not earlier than broadcast
        logic gt;    // stored deadline later than broadcast
        logic match; // valid and owner equals broadcast owner
    } t_cell_sts;

endpackage

/* rtl/stdq_cell.sv */
// One cell of the sorted deadline chain: holds one queued timer entry.
// Compares against the broadcast entry and loads from new, left or right.
// Depends on stdq_pkg.
module stdq_cell
    import stdq_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_valid,
    input  t_slot     i_new,
    input  logic      i_head_ge,
    input  t_slot     i_left,
    input  logic      i_left_take,
    input  t_slot     i_right,
    output t_slot     o_slot,
    output t_cell_sts o_sts
);

    t_slot r_slot;
    logic  gt;
    logic  eq;
    logic  take;

    assign gt   = {r_slot.sec, r_slot.usec} > {i_new.sec, i_new.usec};
    assign eq   = {r_slot.sec, r_slot.usec} == {i_new.sec, i_new.usec};
    // head tie or earlier new deadline pushes the whole row
    assign take = !i_valid || gt || i_head_ge;

    assign o_sts.take  = take;
    assign o_sts.ge    = gt || eq;
    assign o_sts.gt    = gt;
    assign o_sts.match = i_valid && (r_slot.owner == i_new.owner);
    assign o_slot      = r_slot;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins && take) begin
            r_slot <= i_left_take ? i_left : i_new;
        end else if (i_ctl.shl) begin
            r_slot <= i_right;
        end
    end

endmodule

/* rtl/sorted_timer_deadline_queue_core.sv */
// Sorted timer deadline queue: up to DEPTH timers held in a row of cells in deadline
// order (seconds, then microseconds). A request is taken only while the controller is
// idle. Insert and delete are accepted and then applied in one update step in which
// every cell compares against the request and shifts in parallel. A tick pops the
// expired timers from the head one at a time, each with its own result, and then
// gives the sleep report. Every result passes through one output register, so a
// stalled output holds the controller; the next request is taken the cycle after the
// last result of the previous one is loaded. Depends on stdq_pkg and stdq_cell.
module sorted_timer_deadline_queue_core
    import stdq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [55:0] i_s_axis_tdata,   // timer_id[3:0], time_sec[35:4], time_usec[55:36]
    input  logic [1:0]  i_s_axis_tuser,   // cmd[1:0]
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // expired_id[3:0], status[5:4], sleep_sec[37:6],
                                          // sleep_usec[57:38], zero[63:58]
    output logic [1:0]  o_m_axis_tuser,   // kind[1:0]
    output logic        o_m_axis_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = $clog2(DEPTH + 1);

    t_state r_state;
    t_state n_state;

    logic [ID_W-1:0]   r_id;
    logic [SEC_W-1:0]  r_sec;
    logic [USEC_W-1:0] r_usec;

    logic [CW-1:0]         r_count;
    logic [NUM_TIMERS-1:0] r_active;
    logic [SEC_W-1:0]      r_idle_sec;
    logic [USEC_W-1:0]     r_idle_usec;

    logic              r_o_valid;
    t_kind             r_o_kind;
    logic [ID_W-1:0]   r_o_id;
    t_status           r_o_status;
    logic [SEC_W-1:0]  r_o_ssec;
    logic [USEC_W-1:0] r_o_susec;
    logic              r_o_last;

    // chain wiring
    t_slot     slot     [DEPTH];
    t_cell_sts sts      [DEPTH];
    t_cell_ctl cell_ctl [DEPTH];
    logic [DEPTH-1:0] valid_vec;
    logic [DEPTH-1:0] match_vec;
    logic [DEPTH-1:0] del_shl;
    logic [DEPTH-1:0] shl_vec;
    t_slot            new_slot;

    logic  in_acc;
    t_cmd  in_cmd;
    logic  out_free;
    logic  id_active;
    logic  full;
    logic  head_due;
    logic  cfg_wr;

    // emitted result and state updates
    logic              emit;
    t_kind             e_kind;
    logic [ID_W-1:0]   e_id;
    t_status           e_status;
    logic [SEC_W-1:0]  e_ssec;
    logic [USEC_W-1:0] e_susec;
    logic              e_last;
    logic              ins_en;
    logic              cnt_up;
    logic              cnt_dn;
    logic              act_set;
    logic              act_clr;
    logic [ID_W-1:0]   act_id;
    logic [NUM_TIMERS-1:0] act_mask;

    // sleep arithmetic
    logic              borrow;
    logic [SEC_W-1:0]  diff_sec;
    logic [USEC_W:0]   usec_wrap;
    logic [SEC_W-1:0]  sleep_sec;
    logic [USEC_W-1:0] sleep_usec;

    assign in_cmd          = t_cmd'(i_s_axis_tuser);
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_o_valid || i_m_axis_tready;
    assign id_active       = r_active[r_id];
    assign full            = (r_count == CW'(DEPTH));
    assign head_due        = valid_vec[0] && !sts[0].gt;

    assign new_slot.sec   = r_sec;
    assign new_slot.usec  = r_usec;
    assign new_slot.owner = r_id;

    // ---------------------------------------------------------------- cells
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        assign valid_vec[g]    = (r_count > CW'(g));
        assign match_vec[g]    = sts[g].match;
        assign cell_ctl[g].ins = ins_en;
        assign cell_ctl[g].shl = shl_vec[g];

        stdq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (cell_ctl[g]),
            .i_valid     (valid_vec[g]),
            .i_new       (new_slot),
            .i_head_ge   (sts[0].ge),
            .i_left      ((g == 0) ? new_slot : slot[(g == 0) ? 0 : g - 1]),
            .i_left_take ((g == 0) ? 1'b0 : sts[(g == 0) ? 0 : g - 1].take),
            .i_right     (slot[(g == DEPTH - 1) ? g : g + 1]),
            .o_slot      (slot[g]),
            .o_sts       (sts[g])
        );
    end

    // cells at or after the deleted owner close the gap
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            del_shl[i] = |(match_vec & ({DEPTH{1'b1}} >> (DEPTH - 1 - i)));
        end
    end

    // ---------------------------------------------------------------- sleep value
    assign borrow     = r_usec > slot[0].usec;
    assign diff_sec   = slot[0].sec - r_sec;
    assign usec_wrap  = {1'b0, slot[0].usec} + USEC_PER_SEC - {1'b0, r_usec};
    always_comb begin
        if (!valid_vec[0]) begin
            sleep_sec  = r_idle_sec;
            sleep_usec = r_idle_usec;
        end else if (borrow) begin
            sleep_sec  = diff_sec - SEC_W'(1);
            sleep_usec = usec_wrap[USEC_W-1:0];
        end else begin
            sleep_sec  = diff_sec;
            sleep_usec = slot[0].usec - r_usec;
        end
    end

    // ---------------------------------------------------------------- next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (in_cmd)
                        CMD_INSERT: n_state = S_INS;
                        CMD_DELETE: n_state = S_DEL;
                        CMD_TICK:   n_state = S_TICK;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_INS, S_DEL: begin
                if (out_free) n_state = S_IDLE;
            end
            S_TICK: begin
                if (out_free && !head_due) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- state outputs
    always_comb begin
        emit     = 1'b0;
        e_kind   = KIND_EXPIRED;
        e_id     = '0;
        e_status = ST_DONE;
        e_ssec   = '0;
        e_susec  = '0;
        e_last   = 1'b1;
        ins_en   = 1'b0;
        shl_vec  = '0;
        cnt_up   = 1'b0;
        cnt_dn   = 1'b0;
        act_set  = 1'b0;
        act_clr  = 1'b0;
        act_id   = r_id;
        case (r_state)
            S_INS: begin
                if (out_free) begin
                    emit   = 1'b1;
                    e_kind = KIND_INS;
                    e_id   = r_id;
                    if (id_active) begin
                        e_status = ST_IGNORED;
                    end else if (full) begin
                        e_status = ST_FULL;
                    end else begin
                        ins_en  = 1'b1;
                        cnt_up  = 1'b1;
                        act_set = 1'b1;
                    end
                end
            end
            S_DEL: begin
                if (out_free) begin
                    emit   = 1'b1;
                    e_kind = KIND_DEL;
                    e_id   = r_id;
                    if (id_active) begin
                        shl_vec = del_shl;
                        cnt_dn  = 1'b1;
                        act_clr = 1'b1;
                    end else begin
                        e_status = ST_IGNORED;
                    end
                end
            end
            S_TICK: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (head_due) begin
                        // pop the head: every cell takes its right neighbor
                        e_kind  = KIND_EXPIRED;
                        e_id    = slot[0].owner;
                        e_last  = 1'b0;
                        shl_vec = '1;
                        cnt_dn  = 1'b1;
                        act_clr = 1'b1;
                        act_id  = slot[0].owner;
                    end else begin
                        e_kind  = KIND_SLEEP;
                        e_ssec  = sleep_sec;
                        e_susec = sleep_usec;
                    end
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    assign act_mask = NUM_TIMERS'(1) << act_id;

    // ---------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_active  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cnt_up) begin
                r_count <= r_count + CW'(1);
            end else if (cnt_dn) begin
                r_count <= r_count - CW'(1);
            end
            if (act_set) begin
                r_active <= r_active | act_mask;
            end else if (act_clr) begin
                r_active <= r_active & ~act_mask;
            end
            if (emit) begin
                r_o_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // hold the request fields for the update cycles
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_id   <= i_s_axis_tdata[3:0];
            r_sec  <= i_s_axis_tdata[35:4];
            r_usec <= i_s_axis_tdata[55:36];
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_o_kind   <= e_kind;
            r_o_id     <= e_id;
            r_o_status <= e_status;
            r_o_ssec   <= e_ssec;
            r_o_susec  <= e_susec;
            r_o_last   <= e_last;
        end
    end

    // ---------------------------------------------------------------- configuration
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_IDLE_USEC) ? {12'b0, r_idle_usec} : r_idle_sec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_sec  <= SEC_W'(1);
            r_idle_usec <= '0;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_IDLE_SEC) begin
                r_idle_sec <= pwdata;
            end else begin
                r_idle_usec <= pwdata[USEC_W-1:0];
            end
        end
    end

    // ---------------------------------------------------------------- result port
    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tuser  = r_o_kind;
    assign o_m_axis_tlast  = r_o_last;
    assign o_m_axis_tdata  = {6'b0, r_o_susec, r_o_ssec, r_o_status, r_o_id};

    // ---------------------------------------------------------------- checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queued count exceeds depth");

    a_active_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_active) == int'(r_count))
        else $error("active map disagrees with queued count");

    a_head_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CW'(2)) |->
            ({slot[0].sec, slot[0].usec} <= {slot[1].sec, slot[1].usec}))
        else $error("first two entries out of deadline order");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS && emit && e_status == ST_DONE) |=>
            (r_count == $past(r_count) + CW'(1)))
        else $error("accepted insert did not grow the queue");

endmodule
